@@ src/assert_macros.svh @@
// Assertion macros shared by the checker files of the project.
// Depends on nothing; each checker takes it with an include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low reset that disables the check.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication built on the clocked form above.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication built on the clocked form above.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

@@ src/cbts_pkg.sv @@
// Package of the CAN bit timing solver: item types, sequencer states and limits.
// Depends on nothing; used by the top level and its checker.
package cbts_pkg;

    localparam int unsigned PRESC_MAX = 32;
    localparam int unsigned SEG1_MAX  = 32;
    localparam int unsigned SEG2_MAX  = 16;

    // A split can only pass when both halves are multiples of a prescaler of
    // at most PRESC_MAX with quotients inside the segment limits.
    localparam int unsigned T1_MAX = PRESC_MAX * (SEG1_MAX + 1);
    localparam int unsigned T2_MAX = PRESC_MAX * SEG2_MAX;

    localparam int unsigned T1_W   = $clog2(T1_MAX + 1);
    localparam int unsigned T2_W   = $clog2(T2_MAX + 1);
    localparam int unsigned SH_W   = $clog2(T1_W + 1);
    localparam int unsigned P_W    = $clog2(PRESC_MAX + 1);

    localparam logic [31:0] CLOCK_HZ_RESET = 32'd170000000;

    localparam logic [1:0] ATT_EXACT = 2'd0;
    localparam logic [1:0] ATT_PLUS  = 2'd1;
    localparam logic [1:0] ATT_MINUS = 2'd2;

    typedef struct packed {
        logic [31:0] baud_rate;
        logic [15:0] sample_point_q16;
    } cbts_req_t;

    typedef struct packed {
        logic       ok;
        logic [4:0] prescaler_field;
        logic [4:0] seg1_field;
        logic [3:0] seg2_field;
        logic [1:0] attempt_used;
    } cbts_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_COUNT,
        ST_MUL,
        ST_SPLIT,
        ST_GCD_TWOS,
        ST_GCD,
        ST_CHECK_P,
        ST_DIV_T1,
        ST_DIV_T2
    } cbts_state_t;

endpackage

@@ src/can_bit_timing_solver.sv @@
// Top level of the CAN bit timing solver: sequencer, shared divider and result register.
// Depends on cbts_pkg for the item types, the states and the segment limits.
//
// Usage. Write the kernel clock in hertz through cfg_we and cfg_data; it resets to
// 170 MHz. Present a request item and raise start; the item is taken at a rising
// edge where start is high and busy is low, and busy stays high while it is solved.
// The result item stays on result until the next; done marks it for one cycle,
// and the receiver cannot hold it off. Results come out in the order requests went in.
//
// Operation. A zero bit rate gives a failed result in the cycle after the start.
// Otherwise the one shared restoring divider forms the clock count per bit once
// and then, for each of up to three splits that get that far, divides both halves
// by their greatest common divisor. The divisor itself comes from a binary gcd
// loop of single-bit steps on 11-bit values. Splits whose halves exceed T1_MAX or
// T2_MAX are rejected in the split state and cost no divider time; splits whose
// quotients miss the segment limits are rejected only after both divisions.
//
// Reset. rst_n clears the sequencer, the strobe and reloads the clock register;
// the block is then idle and ready for a request.
module can_bit_timing_solver (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cbts_pkg::cbts_req_t request,
    output logic              done,
    output cbts_pkg::cbts_res_t result,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_data
);

    cbts_pkg::cbts_state_t state_reg, state_next;

    logic [31:0] clock_hz_reg;

    // Shared restoring divider: the dividend register shifts out at the top and
    // collects quotient bits at the bottom.
    logic [31:0] div_num_reg, div_num_next;
    logic [31:0] div_den_reg, div_den_next;
    logic [31:0] div_rem_reg, div_rem_next;
    logic [4:0]  div_cnt_reg, div_cnt_next;

    logic [31:0] count_reg, count_next;
    logic [15:0] sp_reg, sp_next;
    logic [31:0] base_reg, base_next;
    logic [1:0]  att_reg, att_next;

    logic [cbts_pkg::T1_W-1:0] t1_reg, t1_next;
    logic [cbts_pkg::T2_W-1:0] t2_reg, t2_next;
    logic [cbts_pkg::T1_W-1:0] ga_reg, ga_next;
    logic [cbts_pkg::T1_W-1:0] gb_reg, gb_next;
    logic [cbts_pkg::SH_W-1:0] k_reg, k_next;
    logic [cbts_pkg::P_W-1:0]  p_reg, p_next;
    logic [cbts_pkg::T1_W-1:0] q1_reg, q1_next;

    logic                done_reg, done_next;
    cbts_pkg::cbts_res_t result_reg, result_next;

    // Divider step.
    logic [32:0] rem_sh;
    logic [32:0] rem_diff;
    logic        rem_ge;
    logic [31:0] rem_step;
    logic [31:0] num_step;
    logic        div_last;

    // Split evaluation.
    logic [47:0] prod;
    logic [33:0] t1_wide;
    logic [31:0] t2_wide;
    logic        split_ok;

    // Gcd result and final checks.
    logic [cbts_pkg::T1_W-1:0] g_val;
    logic [cbts_pkg::T1_W-1:0] p_full;
    logic [cbts_pkg::T1_W-1:0] q2_val;
    logic                      seg_ok;

    assign rem_sh   = {div_rem_reg, div_num_reg[31]};
    assign rem_diff = rem_sh - {1'b0, div_den_reg};
    assign rem_ge   = (rem_sh >= {1'b0, div_den_reg});
    assign rem_step = rem_ge ? rem_diff[31:0] : rem_sh[31:0];
    assign num_step = {div_num_reg[30:0], rem_ge};
    assign div_last = (div_cnt_reg == 5'd31);

    assign prod = {16'd0, count_reg} * {32'd0, sp_reg};

    always_comb
    begin
        case (att_reg)
            cbts_pkg::ATT_PLUS:  t1_wide = {2'b00, base_reg} + 34'd1;
            cbts_pkg::ATT_MINUS: t1_wide = {2'b00, base_reg} - 34'd1;
            default:             t1_wide = {2'b00, base_reg};
        endcase
    end

    assign t2_wide  = count_reg - t1_wide[31:0];
    assign split_ok = !t1_wide[33] && (t1_wide != 34'd0)
                      && (t1_wide < {2'b00, count_reg})
                      && (t1_wide <= 34'(cbts_pkg::T1_MAX))
                      && (t2_wide <= 32'(cbts_pkg::T2_MAX));

    assign g_val  = ga_reg | gb_reg;
    assign p_full = g_val << k_reg;
    assign q2_val = num_step[cbts_pkg::T1_W-1:0];
    assign seg_ok = (q1_reg >= cbts_pkg::T1_W'(2))
                    && (q1_reg <= cbts_pkg::T1_W'(cbts_pkg::SEG1_MAX + 1))
                    && (q2_val >= cbts_pkg::T1_W'(1))
                    && (q2_val <= cbts_pkg::T1_W'(cbts_pkg::SEG2_MAX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cbts_pkg::ST_IDLE;
            done_reg     <= 1'b0;
            clock_hz_reg <= cbts_pkg::CLOCK_HZ_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                clock_hz_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        div_rem_reg <= div_rem_next;
        div_cnt_reg <= div_cnt_next;
        count_reg   <= count_next;
        sp_reg      <= sp_next;
        base_reg    <= base_next;
        att_reg     <= att_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        ga_reg      <= ga_next;
        gb_reg      <= gb_next;
        k_reg       <= k_next;
        p_reg       <= p_next;
        q1_reg      <= q1_next;
        result_reg  <= result_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        div_num_next = div_num_reg;
        div_den_next = div_den_reg;
        div_rem_next = div_rem_reg;
        div_cnt_next = div_cnt_reg;
        count_next   = count_reg;
        sp_next      = sp_reg;
        base_next    = base_reg;
        att_next     = att_reg;
        t1_next      = t1_reg;
        t2_next      = t2_reg;
        ga_next      = ga_reg;
        gb_next      = gb_reg;
        k_next       = k_reg;
        p_next       = p_reg;
        q1_next      = q1_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        case (state_reg)
            cbts_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    sp_next  = request.sample_point_q16;
                    att_next = cbts_pkg::ATT_EXACT;
                    if (request.baud_rate == 32'd0)
                    begin
                        // No count can be formed, so the item fails at once.
                        result_next = '0;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        div_num_next = clock_hz_reg;
                        div_den_next = request.baud_rate;
                        div_rem_next = 32'd0;
                        div_cnt_next = 5'd0;
                        state_next   = cbts_pkg::ST_DIV_COUNT;
                    end
                end
            end

            cbts_pkg::ST_DIV_COUNT:
            begin
                div_num_next = num_step;
                div_rem_next = rem_step;
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_last)
                begin
                    count_next = num_step;
                    state_next = cbts_pkg::ST_MUL;
                end
            end

            cbts_pkg::ST_MUL:
            begin
                base_next  = prod[47:16];
                state_next = cbts_pkg::ST_SPLIT;
            end

            cbts_pkg::ST_SPLIT:
            begin
                if (split_ok)
                begin
                    t1_next    = t1_wide[cbts_pkg::T1_W-1:0];
                    t2_next    = t2_wide[cbts_pkg::T2_W-1:0];
                    ga_next    = t1_wide[cbts_pkg::T1_W-1:0];
                    gb_next    = cbts_pkg::T1_W'(t2_wide[cbts_pkg::T2_W-1:0]);
                    k_next     = '0;
                    state_next = cbts_pkg::ST_GCD_TWOS;
                end
                else if (att_reg == cbts_pkg::ATT_MINUS)
                begin
                    result_next = '0;
                    done_next   = 1'b1;
                    state_next  = cbts_pkg::ST_IDLE;
                end
                else
                begin
                    att_next = att_reg + 2'd1;
                end
            end

            cbts_pkg::ST_GCD_TWOS:
            begin
                // Both halves are nonzero, so this stops at the first odd bit.
                if (!ga_reg[0] && !gb_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    k_next  = k_reg + cbts_pkg::SH_W'(1);
                end
                else
                begin
                    state_next = cbts_pkg::ST_GCD;
                end
            end

            cbts_pkg::ST_GCD:
            begin
                if ((ga_reg == '0) || (gb_reg == '0))
                begin
                    state_next = cbts_pkg::ST_CHECK_P;
                end
                else if (!ga_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                end
                else if (!gb_reg[0])
                begin
                    gb_next = gb_reg >> 1;
                end
                else if (ga_reg >= gb_reg)
                begin
                    ga_next = (ga_reg - gb_reg) >> 1;
                end
                else
                begin
                    gb_next = (gb_reg - ga_reg) >> 1;
                end
            end

            cbts_pkg::ST_CHECK_P:
            begin
                if ((p_full >= cbts_pkg::T1_W'(2))
                    && (p_full <= cbts_pkg::T1_W'(cbts_pkg::PRESC_MAX)))
                begin
                    p_next       = p_full[cbts_pkg::P_W-1:0];
                    div_num_next = 32'(t1_reg);
                    div_den_next = 32'(p_full);
                    div_rem_next = 32'd0;
                    div_cnt_next = 5'd0;
                    state_next   = cbts_pkg::ST_DIV_T1;
                end
                else if (att_reg == cbts_pkg::ATT_MINUS)
                begin
                    result_next = '0;
                    done_next   = 1'b1;
                    state_next  = cbts_pkg::ST_IDLE;
                end
                else
                begin
                    att_next   = att_reg + 2'd1;
                    state_next = cbts_pkg::ST_SPLIT;
                end
            end

            cbts_pkg::ST_DIV_T1:
            begin
                div_num_next = num_step;
                div_rem_next = rem_step;
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_last)
                begin
                    q1_next      = num_step[cbts_pkg::T1_W-1:0];
                    div_num_next = 32'(t2_reg);
                    div_den_next = 32'(p_reg);
                    div_rem_next = 32'd0;
                    div_cnt_next = 5'd0;
                    state_next   = cbts_pkg::ST_DIV_T2;
                end
            end

            cbts_pkg::ST_DIV_T2:
            begin
                div_num_next = num_step;
                div_rem_next = rem_step;
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_last)
                begin
                    if (seg_ok)
                    begin
                        result_next.ok              = 1'b1;
                        result_next.prescaler_field = 5'(p_reg - cbts_pkg::P_W'(1));
                        result_next.seg1_field      = 5'(q1_reg - cbts_pkg::T1_W'(2));
                        result_next.seg2_field      = 4'(q2_val - cbts_pkg::T1_W'(1));
                        result_next.attempt_used    = att_reg;
                        done_next                   = 1'b1;
                        state_next                  = cbts_pkg::ST_IDLE;
                    end
                    else if (att_reg == cbts_pkg::ATT_MINUS)
                    begin
                        result_next = '0;
                        done_next   = 1'b1;
                        state_next  = cbts_pkg::ST_IDLE;
                    end
                    else
                    begin
                        att_next   = att_reg + 2'd1;
                        state_next = cbts_pkg::ST_SPLIT;
                    end
                end
            end

            default:
            begin
                state_next = cbts_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != cbts_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ src/cbts_checker.sv @@
// Port-level checker for the CAN bit timing solver, bound to the top level.
// Depends on cbts_pkg for the item types and on assert_macros.svh.
`include "assert_macros.svh"

module cbts_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input cbts_pkg::cbts_res_t result
);

    // A result is only shown once the block has gone idle again.
    `ASSERT_IMPLIES(a_done_idle, clk, rst_n, done, !busy, "result shown while busy")

    // Every accepted item either starts work or is answered at once.
    `ASSERT_NEXT(a_accept_acts, clk, rst_n, start && !busy, busy || done, "item dropped")

    // Work only begins on an accepted item.
    `ASSERT_IMPLIES(a_busy_cause, clk, rst_n, $rose(busy), $past(start), "busy without start")

    // A failed result carries all-zero fields.
    `ASSERT_IMPLIES(a_fail_zero, clk, rst_n, done && !result.ok, result == '0, "fail not zero")

endmodule

bind can_bit_timing_solver cbts_checker u_cbts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .result   (result)
);
